FILE: rtl/dss_pkg.sv
// ----------------------------------------------------------------------------
// dss_pkg: shared types and constants of the dual stack shared store
// Operation codes, status codes and the command and status bundles that
// join the controller to the datapath.
// ----------------------------------------------------------------------------
package dss_pkg;

  // Default number of words in the shared store.
  localparam int unsigned DSS_DEPTH = 16;
  // A show emits at most this many entries, taken from the top of the stack.
  localparam int unsigned MAX_RESULTS = 16;

  localparam int unsigned KIND_W   = 3;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH_A = 3'd0,
    KIND_POP_A  = 3'd1,
    KIND_SHOW_A = 3'd2,
    KIND_PUSH_B = 3'd3,
    KIND_POP_B  = 3'd4,
    KIND_SHOW_B = 3'd5
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_OVER  = 2'd1,
    STATUS_UNDER = 2'd2
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    sel_b;       // operation works on stack B
    logic    push_en;     // write the pushed word and grow the stack
    logic    pop_en;      // shrink the stack and read its old top
    logic    show_start;  // read the top entry and load the show count
    logic    show_step;   // read the next entry of a running show
    logic    out_ld_stat; // load the output with a status-only result
    status_e out_stat;
    logic    out_ld_data; // load the output with the word just read
  } dss_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic empty_a;
    logic empty_b;
    logic rd_last;        // the word now read is the final one of the item
  } dss_stat_t;

endpackage

FILE: rtl/dss_ctrl.sv
// ----------------------------------------------------------------------------
// dss_ctrl: controller of the dual stack shared store
// Decodes each operation, sequences the reads of pops and shows and owns
// the valid flag of the output register.
// ----------------------------------------------------------------------------
module dss_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [dss_pkg::KIND_W-1:0]  kind_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output dss_pkg::dss_cmd_t           cmd_o,
  input  dss_pkg::dss_stat_t          stat_i
);
  import dss_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_READ = 2'b10
  } state_e;

  state_e   state_q, state_d;
  logic     out_vld_q, out_vld_d;
  logic     out_free;
  logic     accept;
  dss_cmd_t cmd;

  // The output register can take a new result when empty or being drained.
  assign out_free   = !out_vld_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && out_free;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    cmd      = '0;
    cmd.out_stat = STATUS_OK;
    state_d  = state_q;
    cmd.sel_b = (kind_i == KIND_PUSH_B) || (kind_i == KIND_POP_B) ||
                (kind_i == KIND_SHOW_B);
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (kind_i)
            KIND_PUSH_A, KIND_PUSH_B: begin
              cmd.out_ld_stat = 1'b1;
              cmd.out_stat    = stat_i.full ? STATUS_OVER : STATUS_OK;
              cmd.push_en     = !stat_i.full;
            end
            KIND_POP_A, KIND_POP_B, KIND_SHOW_A, KIND_SHOW_B: begin
              if (cmd.sel_b ? stat_i.empty_b : stat_i.empty_a) begin
                cmd.out_ld_stat = 1'b1;
                cmd.out_stat    = STATUS_UNDER;
              end else begin
                cmd.pop_en     = (kind_i == KIND_POP_A) || (kind_i == KIND_POP_B);
                cmd.show_start = !cmd.pop_en;
                state_d        = ST_READ;
              end
            end
            default: begin
              // Unused codes are taken and dropped.
            end
          endcase
        end
      end
      ST_READ: begin
        if (out_free) begin
          cmd.out_ld_data = 1'b1;
          if (stat_i.rd_last) begin
            state_d = ST_IDLE;
          end else begin
            cmd.show_step = 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (cmd.out_ld_stat || cmd.out_ld_data) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  assign cmd_o       = cmd;
  assign out_valid_o = out_vld_q;

endmodule

FILE: rtl/dss_datapath.sv
// ----------------------------------------------------------------------------
// dss_datapath: datapath of the dual stack shared store
// Holds the shared word store, both stack counts, the read pointer and
// count of a running pop or show, and the output payload register.
// ----------------------------------------------------------------------------
module dss_datapath #(
  parameter int unsigned DEPTH = dss_pkg::DSS_DEPTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [dss_pkg::WORD_W-1:0]    value_i,
  input  dss_pkg::dss_cmd_t             cmd_i,
  output dss_pkg::dss_stat_t            stat_o,
  output logic [dss_pkg::WORD_W-1:0]    value_res_o,
  output logic [dss_pkg::STATUS_W-1:0]  status_o,
  output logic                          last_o
);
  import dss_pkg::*;

  localparam int unsigned AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW       = $clog2(DEPTH + 1);
  localparam int unsigned SHOW_CAP = (DEPTH < MAX_RESULTS) ? DEPTH : MAX_RESULTS;

  logic [WORD_W-1:0] mem [DEPTH];

  logic [CW-1:0]     count_a_q, count_a_d;
  logic [CW-1:0]     count_b_q, count_b_d;
  logic [CW-1:0]     rem_q, rem_d;
  logic [AW-1:0]     ptr_q;
  logic              dir_b_q;
  logic [WORD_W-1:0] rdata_q;
  logic [WORD_W-1:0] value_res_q;
  status_e           status_q;
  logic              last_q;

  logic [CW:0]       used;
  logic [CW-1:0]     top_b;
  logic [CW-1:0]     wr_b;
  logic [CW-1:0]     sel_count;
  logic              we;
  logic [AW-1:0]     waddr;
  logic              rd_en;
  logic [AW-1:0]     raddr;

  assign used  = {1'b0, count_a_q} + {1'b0, count_b_q};
  // Top entry of stack B, and the entry a push onto B fills.
  assign top_b = CW'(DEPTH) - count_b_q;
  assign wr_b  = CW'(DEPTH - 1) - count_b_q;

  assign stat_o.full    = used >= (CW + 1)'(DEPTH);
  assign stat_o.empty_a = count_a_q == '0;
  assign stat_o.empty_b = count_b_q == '0;
  assign stat_o.rd_last = rem_q == CW'(1);

  assign sel_count = cmd_i.sel_b ? count_b_q : count_a_q;

  assign we    = cmd_i.push_en;
  assign waddr = cmd_i.sel_b ? wr_b[AW-1:0] : count_a_q[AW-1:0];
  assign rd_en = cmd_i.pop_en || cmd_i.show_start || cmd_i.show_step;

  always_comb begin
    if (cmd_i.show_step) begin
      raddr = dir_b_q ? ptr_q + AW'(1) : ptr_q - AW'(1);
    end else if (cmd_i.sel_b) begin
      raddr = top_b[AW-1:0];
    end else begin
      raddr = AW'(count_a_q - CW'(1));
    end
  end

  always_comb begin
    count_a_d = count_a_q;
    count_b_d = count_b_q;
    if (cmd_i.push_en) begin
      if (cmd_i.sel_b) count_b_d = count_b_q + CW'(1);
      else             count_a_d = count_a_q + CW'(1);
    end else if (cmd_i.pop_en) begin
      if (cmd_i.sel_b) count_b_d = count_b_q - CW'(1);
      else             count_a_d = count_a_q - CW'(1);
    end
  end

  always_comb begin
    rem_d = rem_q;
    if (cmd_i.pop_en) begin
      rem_d = CW'(1);
    end else if (cmd_i.show_start) begin
      rem_d = (sel_count > CW'(SHOW_CAP)) ? CW'(SHOW_CAP) : sel_count;
    end else if (cmd_i.show_step) begin
      rem_d = rem_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_a_q <= '0;
      count_b_q <= '0;
      rem_q     <= '0;
    end else begin
      count_a_q <= count_a_d;
      count_b_q <= count_b_d;
      rem_q     <= rem_d;
    end
  end

  // Shared store with one write and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= value_i;
    end
    if (rd_en) begin
      rdata_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      ptr_q <= raddr;
    end
    if (cmd_i.pop_en || cmd_i.show_start) begin
      dir_b_q <= cmd_i.sel_b;
    end
    if (cmd_i.out_ld_stat) begin
      value_res_q <= '0;
      status_q    <= cmd_i.out_stat;
      last_q      <= 1'b1;
    end else if (cmd_i.out_ld_data) begin
      value_res_q <= rdata_q;
      status_q    <= STATUS_OK;
      last_q      <= stat_o.rd_last;
    end
  end

  assign value_res_o = value_res_q;
  assign status_o    = status_q;
  assign last_o      = last_q;

endmodule

FILE: rtl/dual_stack_shared_store_unit.sv
// ----------------------------------------------------------------------------
// dual_stack_shared_store_unit: two stacks in one shared word store
// Stack A grows up from entry 0 and stack B grows down from the top entry.
// ----------------------------------------------------------------------------
// Usage:
//   Each transfer on the slave channel carries one operation in tuser (push,
//   pop or show on stack A or B) and, for a push, the word in tdata.
//   Each result leaves on the master channel with the word and a status
//   (ok, overflow or underflow); tlast marks the final result of an operation.
//   A push or a failed operation is answered in the cycle after its transfer.
//   A pop or a show reads the store through its registered read port, so the
//   first word passes the read register and then the output register; a show
//   then emits one entry per cycle while the receiver does not stall, at most
//   MAX_RESULTS entries from the top down. A push or an error result leaves
//   the controller idle; a pop or show holds the slave channel to its last word.
//   Unused operation codes are taken and dropped with no result.
//   When the receiver stalls, the output register holds its result and the
//   block waits; no result is dropped or repeated.
//   Reset empties both stacks; the store contents are undefined until written,
//   and only written entries are ever read.
// ----------------------------------------------------------------------------
module dual_stack_shared_store_unit #(
  parameter int unsigned DEPTH = dss_pkg::DSS_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] value (signed)
  input  logic [2:0]  s_axis_tuser,   // [2:0] kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] value_res (signed), [33:32] status
  output logic        m_axis_tlast    // last
);
  import dss_pkg::*;

  dss_cmd_t            cmd;
  dss_stat_t           stat;
  logic [WORD_W-1:0]   value_res;
  logic [STATUS_W-1:0] status;

  dss_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .kind_i      (s_axis_tuser),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  dss_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .value_i     (s_axis_tdata),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .value_res_o (value_res),
    .status_o    (status),
    .last_o      (m_axis_tlast)
  );

  assign m_axis_tdata = {6'b0, status, value_res};

endmodule

FILE: test/dual_stack_shared_store_unit_tb.sv
// ----------------------------------------------------------------------------
// dual_stack_shared_store_unit_tb: self-checking bench for the dual stack unit
// Feeds push, pop and show operations on both stacks while an in-bench copy
// of both stacks and their shared store predicts every result. Each result
// transfer is checked field by field against the oldest prediction. The
// sender idles in random bursts, and the receiver stalls on its own pattern,
// including one long hold-off that backs the block up into its input.
// ----------------------------------------------------------------------------
module dual_stack_shared_store_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dss_pkg::*;

  localparam int unsigned CLK_HALF      = 10;
  localparam int unsigned RESET_CYCLES  = 8;
  localparam int unsigned HOLD_CYCLES   = 200;
  localparam int unsigned TAIL_CYCLES   = 20;
  localparam int unsigned RANDOM_ITEMS  = 16;
  localparam int unsigned REPORT_LIMIT  = 10;
  localparam longint      RUN_LIMIT_NS  = 10_000_000;

  // Operation codes that the block takes and drops without a result.
  localparam logic [KIND_W-1:0] KIND_RSVD_LO = 3'd6;
  localparam logic [KIND_W-1:0] KIND_RSVD_HI = 3'd7;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    status_e           status;
    logic              last;
  } stack_result_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;   // [31:0] value (signed)
  logic [2:0]  s_axis_tuser  = '0;   // [2:0] kind
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;         // [31:0] value_res (signed), [33:32] status
  logic        m_axis_tlast;         // last

  // Shadow copy of the two stacks.
  logic [WORD_W-1:0] shadow_mem [DSS_DEPTH];
  int unsigned       depth_a = 0;
  int unsigned       depth_b = 0;
  stack_result_t     pending_results [$];

  int unsigned mismatches    = 0;
  int unsigned burst_left    = 0;
  bit          steady_send   = 1'b0;
  int unsigned hold_requests = 0;
  int unsigned hold_seen     = 0;
  int unsigned hold_left     = 0;
  logic [15:0] rx_cycle      = '0;

  dual_stack_shared_store_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #(CLK_HALF) clk_i = 1'b1;
    #(CLK_HALF) clk_i = 1'b0;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("*** FAILED ***");
    $finish;
  end

  function automatic void queue_result(input logic [WORD_W-1:0] word, input status_e status,
                                       input logic last);
    stack_result_t res;
    res.word   = word;
    res.status = status;
    res.last   = last;
    pending_results.push_back(res);
  endfunction

  // Applies one accepted operation to the shadow stacks and queues its results.
  function automatic void predict_stack_op(input logic [KIND_W-1:0] kind,
                                           input logic [WORD_W-1:0] value);
    bit          is_full;
    bit          on_b;
    int unsigned n;
    int unsigned idx;
    is_full = (depth_a + depth_b) >= DSS_DEPTH;
    case (kind)
      KIND_PUSH_A: begin
        if (is_full) begin
          queue_result('0, STATUS_OVER, 1'b1);
        end else begin
          shadow_mem[depth_a] = value;
          depth_a++;
          queue_result('0, STATUS_OK, 1'b1);
        end
      end
      KIND_PUSH_B: begin
        if (is_full) begin
          queue_result('0, STATUS_OVER, 1'b1);
        end else begin
          depth_b++;
          shadow_mem[DSS_DEPTH - depth_b] = value;
          queue_result('0, STATUS_OK, 1'b1);
        end
      end
      KIND_POP_A: begin
        if (depth_a == 0) begin
          queue_result('0, STATUS_UNDER, 1'b1);
        end else begin
          depth_a--;
          queue_result(shadow_mem[depth_a], STATUS_OK, 1'b1);
        end
      end
      KIND_POP_B: begin
        if (depth_b == 0) begin
          queue_result('0, STATUS_UNDER, 1'b1);
        end else begin
          queue_result(shadow_mem[DSS_DEPTH - depth_b], STATUS_OK, 1'b1);
          depth_b--;
        end
      end
      KIND_SHOW_A, KIND_SHOW_B: begin
        on_b = (kind == KIND_SHOW_B);
        n = on_b ? depth_b : depth_a;
        if (n == 0) begin
          queue_result('0, STATUS_UNDER, 1'b1);
        end else begin
          if (n > MAX_RESULTS) n = MAX_RESULTS;
          for (int unsigned k = 0; k < n; k++) begin
            idx = on_b ? (DSS_DEPTH - depth_b + k) : (depth_a - 1 - k);
            queue_result(shadow_mem[idx], STATUS_OK, (k + 1 == n));
          end
        end
      end
      default: begin
        // Unused codes leave the stacks alone and answer nothing.
      end
    endcase
  endfunction

  function automatic void note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) $display("MISMATCH at %0t: %s", $time, msg);
  endfunction

  // Mostly random words, with the signed extremes mixed in.
  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 11))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom();
    endcase
  endfunction

  // Breaks the input stream into bursts with idle gaps between them.
  task automatic pace_sender();
    int unsigned gap;
    if (!steady_send) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(0, 15);
        gap = $urandom_range(0, 6);
        if (gap != 0) begin
          s_axis_tvalid <= 1'b0;
          s_axis_tuser  <= KIND_W'($urandom());
          s_axis_tdata  <= $urandom();
          repeat (gap) @(posedge clk_i);
        end
      end
    end
  endtask

  // Offers one operation and waits for its transfer. Called at a rising edge.
  task automatic send_op(input logic [KIND_W-1:0] kind, input logic [WORD_W-1:0] value);
    logic taken;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= value;
    do begin
      @(negedge clk_i);
      taken = s_axis_tready;
      @(posedge clk_i);
    end while (!taken);
    predict_stack_op(kind, value);
    pace_sender();
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  task automatic test_empty_stacks();
    send_op(KIND_POP_A, $urandom());
    send_op(KIND_POP_B, $urandom());
    send_op(KIND_SHOW_A, $urandom());
    send_op(KIND_SHOW_B, $urandom());
  endtask

  task automatic test_word_extremes();
    send_op(KIND_PUSH_A, 32'h8000_0000);
    send_op(KIND_PUSH_A, 32'h7fff_ffff);
    send_op(KIND_PUSH_B, 32'h0000_0000);
    send_op(KIND_PUSH_B, 32'hffff_ffff);
    send_op(KIND_SHOW_A, 32'hffff_ffff);
    send_op(KIND_SHOW_B, 32'h0000_0000);
    send_op(KIND_POP_A, $urandom());
    send_op(KIND_POP_B, $urandom());
    send_op(KIND_POP_A, $urandom());
    send_op(KIND_POP_B, $urandom());
  endtask

  task automatic test_unused_kinds();
    send_op(KIND_RSVD_LO, $urandom());
    send_op(KIND_RSVD_HI, $urandom());
    send_op(KIND_SHOW_A, $urandom());
  endtask

  // Fills the store from one side, the other side, and both, then empties it.
  task automatic test_fill_and_overflow();
    int unsigned split;
    repeat (DSS_DEPTH) send_op(KIND_PUSH_A, pick_word());
    send_op(KIND_PUSH_A, pick_word());
    send_op(KIND_PUSH_B, pick_word());
    send_op(KIND_SHOW_A, $urandom());
    send_op(KIND_SHOW_B, $urandom());
    repeat (DSS_DEPTH) send_op(KIND_POP_A, $urandom());

    repeat (DSS_DEPTH) send_op(KIND_PUSH_B, pick_word());
    send_op(KIND_PUSH_B, pick_word());
    send_op(KIND_PUSH_A, pick_word());
    send_op(KIND_SHOW_B, $urandom());
    send_op(KIND_SHOW_A, $urandom());
    repeat (DSS_DEPTH) send_op(KIND_POP_B, $urandom());

    split = $urandom_range(1, DSS_DEPTH - 1);
    repeat (split) send_op(KIND_PUSH_A, pick_word());
    repeat (DSS_DEPTH - split) send_op(KIND_PUSH_B, pick_word());
    send_op(KIND_PUSH_A, pick_word());
    send_op(KIND_SHOW_A, $urandom());
    send_op(KIND_SHOW_B, $urandom());
    repeat (split) send_op(KIND_POP_A, $urandom());
    repeat (DSS_DEPTH - split) send_op(KIND_POP_B, $urandom());
  endtask

  // The receiver holds off while the sender keeps offering, so the block backs
  // up and stalls its input; then the sender waits for every result.
  task automatic test_output_backpressure();
    steady_send = 1'b1;
    hold_requests++;
    repeat (3) send_op(KIND_PUSH_A, pick_word());
    repeat (3) send_op(KIND_PUSH_B, pick_word());
    send_op(KIND_SHOW_A, $urandom());
    send_op(KIND_SHOW_B, $urandom());
    send_op(KIND_POP_A, $urandom());
    send_op(KIND_POP_B, $urandom());
    wait_drained();
    steady_send = 1'b0;
  endtask

  // Alternates push-heavy and pop-heavy stretches so that both stacks grow
  // and shrink again.
  task automatic test_random_mix();
    int unsigned done;
    int unsigned roll;
    bit          grow;
    bit          on_b;
    logic [KIND_W-1:0] kind;
    done = 0;
    while (done < RANDOM_ITEMS) begin
      grow = ((done / 8) % 2) == 0;
      steady_send = (done % 16) >= 12;
      roll = $urandom_range(0, 99);
      on_b = 1'($urandom_range(0, 1));
      if (roll < 4) begin
        kind = $urandom_range(0, 1) ? KIND_RSVD_HI : KIND_RSVD_LO;
      end else if (roll < (grow ? 60 : 30)) begin
        kind = on_b ? KIND_PUSH_B : KIND_PUSH_A;
      end else if (roll < (grow ? 80 : 78)) begin
        kind = on_b ? KIND_POP_B : KIND_POP_A;
      end else begin
        kind = on_b ? KIND_SHOW_B : KIND_SHOW_A;
      end
      send_op(kind, pick_word());
      if (kind != KIND_RSVD_LO && kind != KIND_RSVD_HI) done++;
    end
    steady_send = 1'b0;
  endtask

  // Receiver: its own stall pattern, cycling through several modes, plus a
  // long hold-off whenever the test asks for one.
  always @(posedge clk_i) begin
    rx_cycle <= rx_cycle + 1'b1;
    if (hold_seen != hold_requests) begin
      hold_seen     <= hold_requests;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      case (rx_cycle[8:7])
        2'd0:    m_axis_tready <= 1'b1;
        2'd1:    m_axis_tready <= ($urandom_range(0, 3) != 0);
        2'd2:    m_axis_tready <= 1'($urandom_range(0, 1));
        default: m_axis_tready <= (rx_cycle[3:0] < 4'd11);
      endcase
    end
  end

  // Outputs are stable between edges, so a transfer seen here happens at the
  // next rising edge.
  always @(negedge clk_i) begin
    stack_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        note_mismatch($sformatf("unexpected result tdata=%h tlast=%b",
                                m_axis_tdata, m_axis_tlast));
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[WORD_W-1:0] !== want.word ||
            m_axis_tdata[WORD_W+STATUS_W-1:WORD_W] !== want.status ||
            m_axis_tdata[39:WORD_W+STATUS_W] !== '0 ||
            m_axis_tlast !== want.last) begin
          note_mismatch($sformatf(
            "expected word=%h status=%s last=%b, got word=%h status=%0d pad=%h last=%b",
            want.word, want.status.name(), want.last, m_axis_tdata[WORD_W-1:0],
            m_axis_tdata[WORD_W+STATUS_W-1:WORD_W], m_axis_tdata[39:WORD_W+STATUS_W],
            m_axis_tlast));
        end
      end
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_stacks();
    test_word_extremes();
    test_unused_kinds();
    test_fill_and_overflow();
    test_output_backpressure();
    test_random_mix();

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/dss_pkg.sv
rtl/dss_ctrl.sv
rtl/dss_datapath.sv
rtl/dual_stack_shared_store_unit.sv
test/dual_stack_shared_store_unit_tb.sv
